// ----- hdl/png_scanline_unfilter_assert.svh -----
// assertion macros for the scanline unfilter
`ifndef PNG_SCANLINE_UNFILTER_ASSERT_SVH
`define PNG_SCANLINE_UNFILTER_ASSERT_SVH

// condition must hold whenever the block is out of reset
`define PSU_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("png_scanline_unfilter: invariant violated");

// same-cycle implication
`define PSU_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("png_scanline_unfilter: implication violated");

// next-cycle implication
`define PSU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("png_scanline_unfilter: sequence violated");

`endif

// ----- hdl/psu_pkg.sv -----
// shared types, constants and functions of the scanline unfilter
package psu_pkg;

   localparam int MaxWidth         = 1024;
   localparam int MaxBytesPerPixel = 4;
   localparam int StoreDepth       = MaxWidth * MaxBytesPerPixel;
   localparam int AddrBits         = $clog2(StoreDepth);
   localparam int LaneBits         = $clog2(MaxBytesPerPixel);

   typedef enum logic [1:0] {
      CSR_IMAGE_WIDTH     = 2'd0,
      CSR_IMAGE_HEIGHT    = 2'd1,
      CSR_BYTES_PER_PIXEL = 2'd2
   } csr_index_type;

   localparam logic [7:0] FILTER_NONE    = 8'd0;
   localparam logic [7:0] FILTER_SUB     = 8'd1;
   localparam logic [7:0] FILTER_UP      = 8'd2;
   localparam logic [7:0] FILTER_AVERAGE = 8'd3;
   localparam logic [7:0] FILTER_PAETH   = 8'd4;

   typedef struct packed {
      logic [7:0] pixel_byte;
      logic       end_of_row;
      logic       end_of_image;
      logic       bad_filter;
   } rsp_type;

   function automatic logic [8:0] abs_diff9(input logic [7:0] x, input logic [7:0] y);
      logic [8:0] d;
      d = {1'b0, x} - {1'b0, y};
      abs_diff9 = d[8] ? (9'd0 - d) : d;
   endfunction

   // predictor: pick the neighbour closest to left + upper - upper_left
   function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
      logic [8:0]  pa;
      logic [8:0]  pb;
      logic [9:0]  sum_ab;
      logic [9:0]  two_c;
      logic [9:0]  dc;
      logic [9:0]  pc;
      pa     = abs_diff9(b, c);
      pb     = abs_diff9(a, c);
      sum_ab = {2'b00, a} + {2'b00, b};
      two_c  = {1'b0, c, 1'b0};
      dc     = sum_ab - two_c;
      pc     = dc[9] ? (10'd0 - dc) : dc;
      if (({1'b0, pa} <= {1'b0, pb}) && ({1'b0, pa} <= pc)) begin
         paeth = a;
      end else if ({1'b0, pb} <= pc) begin
         paeth = b;
      end else begin
         paeth = c;
      end
   endfunction

endpackage

// ----- hdl/psu_rsp_fifo.sv -----
// two-entry result queue between the datapath and the rsp channel
module psu_rsp_fifo
   import psu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    full,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic [1:0] count_ff;
   logic [1:0] count_in;
   rsp_type    head_ff;
   rsp_type    head_in;
   rsp_type    tail_ff;
   rsp_type    tail_in;
   logic       pop;

   assign pop       = (count_ff != 2'd0) && !rsp_stall;
   assign full      = (count_ff == 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = head_ff;

   always_comb begin
      count_in = count_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      case ({push, pop})
         2'b11: begin
            if (count_ff == 2'd2) begin
               head_in = tail_ff;
               tail_in = push_data;
            end else begin
               head_in = push_data;
            end
         end
         2'b10: begin
            count_in = count_ff + 2'd1;
            if (count_ff == 2'd0) begin
               head_in = push_data;
            end else begin
               tail_in = push_data;
            end
         end
         2'b01: begin
            count_in = count_ff - 2'd1;
            head_in  = tail_ff;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

endmodule

// ----- hdl/png_scanline_unfilter.sv -----
// top level of the png scanline unfilter
//
// req channel: one inflated byte per item on req_stream_byte. the first byte of
// each scanline is the filter type and gives no result; every other byte gives
// one rsp item with the rebuilt pixel_byte and end_of_row, end_of_image and
// bad_filter flags. row length is image_width * bytes_per_pixel bytes.
// csr port: csr_wr_en writes csr_wr_data into the register csr_index selects;
// write only between items. width and bytes per pixel are clamped to range.
// results: each rebuilt byte is registered in the result queue before rsp.
// throughput: one byte per cycle while req_stall is low; the previous row sits
// in a 4096 x 8 line store read through a register at the next byte position,
// with write-to-read forwarding; the left neighbour comes from lane registers.
// stall: a two-entry result queue keeps req open while one result waits;
// req_stall rises only when both entries are held.
// reset: synchronous, clears counters and histories and waits for a filter byte;
// the line store is not cleared and reads only rows written since.
`include "png_scanline_unfilter_assert.svh"

module png_scanline_unfilter
   import psu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_stream_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_pixel_byte,
   output logic        rsp_end_of_row,
   output logic        rsp_end_of_image,
   output logic        rsp_bad_filter,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wr_data
);

   logic [10:0]         width_ff;
   logic [15:0]         height_ff;
   logic [2:0]          bpp_ff;

   logic [7:0]          line_store_ff [StoreDepth];
   logic [7:0]          store_rd_ff;
   logic                fwd_ff;
   logic [7:0]          fwd_data_ff;

   logic [7:0]          left_hist_ff [MaxBytesPerPixel];
   logic [7:0]          upper_left_hist_ff [MaxBytesPerPixel];
   logic [7:0]          row_filter_ff;
   logic [AddrBits-1:0] byte_in_row_ff;
   logic [AddrBits-1:0] byte_in_row_in;
   logic [15:0]         row_index_ff;
   logic [15:0]         row_index_in;
   logic                awaiting_filter_ff;

   logic [10:0]         w_eff;
   logic [2:0]          bpp_eff;
   logic [15:0]         h_eff;
   logic [13:0]         row_len;
   logic [23:0]         mod3_prod;
   logic [10:0]         mod3_q;
   logic [AddrBits:0]   mod3_r;
   logic [LaneBits-1:0] lane;
   logic                has_left;
   logic                has_top;
   logic [7:0]          a;
   logic [7:0]          b;
   logic [7:0]          c;
   logic [8:0]          sum_ab;
   logic [7:0]          res;
   logic                bad;
   logic                end_row;
   logic                end_img;
   logic                accept;
   logic                data_acc;
   rsp_type             push_data;
   rsp_type             rsp_data;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 11'd1;
         height_ff <= 16'd1;
         bpp_ff    <= 3'd1;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH:     width_ff  <= csr_wr_data[10:0];
            CSR_IMAGE_HEIGHT:    height_ff <= csr_wr_data;
            CSR_BYTES_PER_PIXEL: bpp_ff    <= csr_wr_data[2:0];
            default:             width_ff  <= width_ff;
         endcase
      end
   end

   always_comb begin
      if (width_ff == 11'd0) begin
         w_eff = 11'd1;
      end else if (width_ff > 11'(MaxWidth)) begin
         w_eff = 11'(MaxWidth);
      end else begin
         w_eff = width_ff;
      end
      if (bpp_ff == 3'd0) begin
         bpp_eff = 3'd1;
      end else if (bpp_ff > 3'(MaxBytesPerPixel)) begin
         bpp_eff = 3'(MaxBytesPerPixel);
      end else begin
         bpp_eff = bpp_ff;
      end
      h_eff = (height_ff == 16'd0) ? 16'd1 : height_ff;
   end

   assign row_len = {3'b000, w_eff} * {11'd0, bpp_eff};

   // lane = position mod bytes per pixel; mod 3 by reciprocal 2731 / 8192
   assign mod3_prod = 24'({12'd0, byte_in_row_ff} * 24'd2731);
   assign mod3_q    = mod3_prod[23:13];
   assign mod3_r    = {1'b0, byte_in_row_ff} - (13'({mod3_q, 1'b0}) + 13'(mod3_q));

   always_comb begin
      case (bpp_eff)
         3'd2:    lane = {1'b0, byte_in_row_ff[0]};
         3'd3:    lane = mod3_r[1:0];
         3'd4:    lane = byte_in_row_ff[1:0];
         default: lane = '0;
      endcase
   end

   assign has_left = {2'b00, byte_in_row_ff} >= 14'(bpp_eff);
   assign has_top  = (row_index_ff != 16'd0);

   assign a = has_left ? left_hist_ff[lane] : 8'd0;
   assign b = has_top ? (fwd_ff ? fwd_data_ff : store_rd_ff) : 8'd0;
   assign c = (has_left && has_top) ? upper_left_hist_ff[lane] : 8'd0;

   assign sum_ab = {1'b0, a} + {1'b0, b};

   always_comb begin
      bad = 1'b0;
      case (row_filter_ff)
         FILTER_NONE:    res = req_stream_byte;
         FILTER_SUB:     res = req_stream_byte + a;
         FILTER_UP:      res = req_stream_byte + b;
         FILTER_AVERAGE: res = req_stream_byte + sum_ab[8:1];
         FILTER_PAETH:   res = req_stream_byte + paeth(a, b, c);
         default: begin
            res = 8'd0;
            bad = 1'b1;
         end
      endcase
   end

   assign end_row  = (14'(byte_in_row_ff) + 14'd1) >= row_len;
   assign end_img  = (17'(row_index_ff) + 17'd1) >= 17'(h_eff);

   assign accept   = req_valid && !req_stall;
   assign data_acc = accept && !awaiting_filter_ff;

   always_comb begin
      byte_in_row_in = byte_in_row_ff;
      row_index_in   = row_index_ff;
      if (data_acc) begin
         if (end_row) begin
            byte_in_row_in = '0;
            row_index_in   = end_img ? 16'd0 : row_index_ff + 16'd1;
         end else begin
            byte_in_row_in = byte_in_row_ff + AddrBits'(1);
         end
      end
   end

   // line store: read one position ahead, forward a same-entry write
   always_ff @(posedge clock) begin
      if (data_acc) begin
         line_store_ff[byte_in_row_ff] <= res;
      end
      store_rd_ff <= line_store_ff[byte_in_row_in];
      fwd_data_ff <= res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff             <= 1'b0;
         row_filter_ff      <= FILTER_NONE;
         byte_in_row_ff     <= '0;
         row_index_ff       <= 16'd0;
         awaiting_filter_ff <= 1'b1;
         for (int i = 0; i < MaxBytesPerPixel; i++) begin
            left_hist_ff[i]       <= 8'd0;
            upper_left_hist_ff[i] <= 8'd0;
         end
      end else begin
         fwd_ff         <= data_acc && (byte_in_row_ff == byte_in_row_in);
         byte_in_row_ff <= byte_in_row_in;
         row_index_ff   <= row_index_in;
         if (accept && awaiting_filter_ff) begin
            row_filter_ff      <= req_stream_byte;
            awaiting_filter_ff <= 1'b0;
         end
         if (data_acc) begin
            left_hist_ff[lane]       <= res;
            upper_left_hist_ff[lane] <= b;
            if (end_row) begin
               awaiting_filter_ff <= 1'b1;
            end
         end
      end
   end

   assign push_data.pixel_byte   = res;
   assign push_data.end_of_row   = end_row;
   assign push_data.end_of_image = end_row && end_img;
   assign push_data.bad_filter   = bad;

   psu_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (data_acc),
      .push_data (push_data),
      .full      (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_pixel_byte   = rsp_data.pixel_byte;
   assign rsp_end_of_row   = rsp_data.end_of_row;
   assign rsp_end_of_image = rsp_data.end_of_image;
   assign rsp_bad_filter   = rsp_data.bad_filter;

   `PSU_ASSERT_IMPLY(a_stall_needs_rsp, clock, reset, req_stall, rsp_valid)
   `PSU_ASSERT_IMPLY(a_image_end_is_row_end, clock, reset,
                     rsp_valid && rsp_end_of_image, rsp_end_of_row)
   `PSU_ASSERT_IMPLY(a_bad_filter_zero, clock, reset,
                     rsp_valid && rsp_bad_filter, rsp_pixel_byte == 8'd0)
   `PSU_ASSERT_NEXT(a_row_end_waits_filter, clock, reset,
                    data_acc && end_row, awaiting_filter_ff && (byte_in_row_ff == '0))

endmodule
